/* rtl/brs_pkg.sv */
// Package for the 2x Butterworth resampler: fixed-point widths, filter
// coefficients and the command/status types between controller and datapath.
// No dependencies.
package brs_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SFB       = 16;
	localparam int STATE_W   = 40;
	localparam int EXT_W     = STATE_W + 2;
	localparam int COEF_W    = 24;
	localparam int COEF_FRAC = 22;
	localparam int ACC_W     = STATE_W + COEF_W;

	localparam logic signed [COEF_W-1:0] S1_GAIN = COEF_W'(283136);
	localparam logic signed [COEF_W-1:0] S1_OLD  = -COEF_W'(1893344);
	localparam logic signed [COEF_W-1:0] S1_NEW  = COEF_W'(952318);
	localparam logic signed [COEF_W-1:0] S2_GAIN = COEF_W'(1) << COEF_FRAC;
	localparam logic signed [COEF_W-1:0] S2_OLD  = -COEF_W'(191885);
	localparam logic signed [COEF_W-1:0] S2_NEW  = COEF_W'(686151);

	localparam logic signed [EXT_W-1:0] ST_MAX = EXT_W'({1'b0, {(STATE_W-1){1'b1}}});
	localparam logic signed [EXT_W-1:0] ST_MIN = -ST_MAX - EXT_W'(1);

	typedef enum logic [1:0] {
		MAC_IN,
		MAC_OLD,
		MAC_NEW
	} mac_sel_t;

	typedef struct packed {
		logic     load;
		logic     mac_en;
		mac_sel_t sel;
		logic     finish;
		logic     emit;
		logic     last;
		logic     sec;
		logic     dir;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [EXT_W-1:0] v);
		logic signed [EXT_W-1:0] r;
		begin
			if (v > ST_MAX) r = ST_MAX;
			else if (v < ST_MIN) r = ST_MIN;
			else r = v;
			return r[STATE_W-1:0];
		end
	endfunction

endpackage

/* rtl/brs_ctrl.sv */
// Sequencer for the 2x resampler: steps each biquad section through its
// multiply-accumulate and update steps and schedules the output transactions.
// Depends on brs_pkg.
module brs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_tuser,
	input  brs_pkg::status_t status,
	output brs_pkg::cmd_t   cmd
);
	import brs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC_IN,
		ST_MAC_OLD,
		ST_MAC_NEW,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   pass_q;
	logic   sec_q;
	logic   op_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.sec    = sec_q;
		cmd.dir    = op_q;
		cmd.last   = pass_q | ~op_q;
		cmd.sel    = MAC_IN;
		cmd.load   = (state_q == ST_IDLE) && s_tvalid;
		cmd.finish = (state_q == ST_FINISH);
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
		case (state_q)
			ST_MAC_IN: begin
				cmd.mac_en = 1'b1;
				cmd.sel    = MAC_IN;
			end
			ST_MAC_OLD: begin
				cmd.mac_en = 1'b1;
				cmd.sel    = MAC_OLD;
			end
			ST_MAC_NEW: begin
				cmd.mac_en = 1'b1;
				cmd.sel    = MAC_NEW;
			end
			default: begin
				cmd.mac_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			sec_q   <= 1'b0;
			op_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						pass_q  <= 1'b0;
						sec_q   <= 1'b0;
						state_q <= ST_MAC_IN;
					end
				end
				ST_MAC_IN:  state_q <= ST_MAC_OLD;
				ST_MAC_OLD: state_q <= ST_MAC_NEW;
				ST_MAC_NEW: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!sec_q) begin
						sec_q   <= 1'b1;
						state_q <= ST_MAC_IN;
					end else if (pass_q && !op_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						if (pass_q) begin
							state_q <= ST_IDLE;
						end else begin
							pass_q  <= 1'b1;
							sec_q   <= 1'b0;
							state_q <= ST_MAC_IN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/brs_dpath.sv */
// Datapath for the 2x resampler: filter delay registers for both directions,
// one shared 40x24 multiplier with accumulator, PCM conversion and output register.
// Depends on brs_pkg.
module brs_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [31:0]                        s_tdata,
	input  brs_pkg::cmd_t                      cmd,
	output brs_pkg::status_t                   status,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic signed [brs_pkg::SAMPLE_W-1:0] m_sample,
	output logic                               m_last
);
	import brs_pkg::*;

	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) << (SFB - 1);
	localparam logic signed [EXT_W-1:0] BIAS = (EXT_W'(1) << SFB) - EXT_W'(1);
	localparam logic signed [EXT_W-1:0] PCM_MAX = EXT_W'(32767);
	localparam logic signed [EXT_W-1:0] PCM_MIN = -EXT_W'(32768);

	logic signed [STATE_W-1:0]  d0_q [2][2];
	logic signed [STATE_W-1:0]  d1_q [2][2];
	logic signed [STATE_W-1:0]  x_q;
	logic signed [SAMPLE_W-1:0] second_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;

	logic signed [SAMPLE_W-1:0] first_in;
	logic signed [SAMPLE_W-1:0] second_in;
	logic signed [STATE_W-1:0]  d0_sel;
	logic signed [STATE_W-1:0]  d1_sel;
	logic signed [STATE_W-1:0]  mul_a;
	logic signed [COEF_W-1:0]   mul_b;
	logic signed [ACC_W-1:0]    prod;
	logic signed [ACC_W-1:0]    rnd;
	logic signed [ACC_W-1:0]    shft;
	logic signed [EXT_W-1:0]    w_ext;
	logic signed [STATE_W-1:0]  w;
	logic signed [EXT_W-1:0]    y_ext;
	logic signed [STATE_W-1:0]  y;
	logic signed [STATE_W:0]    ky;
	logic signed [EXT_W-1:0]    t;
	logic signed [EXT_W-1:0]    tb;
	logic signed [EXT_W-1:0]    q;
	logic signed [SAMPLE_W-1:0] pcm;

	assign first_in  = s_tdata[15:0];
	assign second_in = s_tdata[31:16];
	assign d0_sel    = d0_q[cmd.dir][cmd.sec];
	assign d1_sel    = d1_q[cmd.dir][cmd.sec];

	always_comb begin
		case (cmd.sel)
			MAC_IN: begin
				mul_a = x_q;
				mul_b = cmd.sec ? S2_GAIN : S1_GAIN;
			end
			MAC_OLD: begin
				mul_a = d0_sel;
				mul_b = cmd.sec ? S2_OLD : S1_OLD;
			end
			MAC_NEW: begin
				mul_a = d1_sel;
				mul_b = cmd.sec ? S2_NEW : S1_NEW;
			end
			default: begin
				mul_a = x_q;
				mul_b = S1_GAIN;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		rnd   = acc_q + RND;
		shft  = rnd >>> COEF_FRAC;
		w_ext = shft[EXT_W-1:0];
		w     = sat_state(w_ext);
		y_ext = EXT_W'(d0_sel) + (EXT_W'(d1_sel) <<< 1) + EXT_W'(w);
		y     = sat_state(y_ext);
	end

	always_comb begin
		ky = cmd.dir ? {x_q, 1'b0} : {x_q[STATE_W-1], x_q};
		t  = EXT_W'(ky) + HALF;
		tb = t[EXT_W-1] ? (t + BIAS) : t;
		q  = tb >>> SFB;
		if (q > PCM_MAX) pcm = PCM_MAX[SAMPLE_W-1:0];
		else if (q < PCM_MIN) pcm = PCM_MIN[SAMPLE_W-1:0];
		else pcm = q[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					d0_q[i][j] <= '0;
					d1_q[i][j] <= '0;
				end
			end
			valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				d0_q[cmd.dir][cmd.sec] <= d1_sel;
				d1_q[cmd.dir][cmd.sec] <= w;
			end
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= STATE_W'(first_in) <<< SFB;
			second_q <= second_in;
		end else if (cmd.finish) begin
			x_q <= y;
		end else if (cmd.emit) begin
			x_q <= cmd.dir ? '0 : (STATE_W'(second_q) <<< SFB);
		end
		if (cmd.mac_en) begin
			acc_q <= (cmd.sel == MAC_IN) ? prod : (acc_q + prod);
		end
		if (cmd.emit) begin
			sample_q <= pcm;
			last_q   <= cmd.last;
		end
	end

	assign status.out_free = !valid_q || m_tready;
	assign m_tvalid        = valid_q;
	assign m_sample        = sample_q;
	assign m_last          = last_q;

endmodule

/* rtl/butterworth_resampler_2x.sv */
// Top level of the 2x Butterworth resampler: sequencer plus datapath.
// Depends on brs_pkg, brs_ctrl and brs_dpath.
//
// A 2x audio rate changer around a fixed order-4 Butterworth lowpass (two
// cascaded biquads, state in signed Q24.16 over 40 bits). tuser = 0 filters
// the sample pair in tdata through the downsample filter and returns the
// filtered first sample as one transaction with tlast set; tuser = 1 filters
// the first sample and then a zero through the upsample filter and returns
// both results doubled, the second with tlast set. Each filter run steps
// through both biquad sections, each through MAC_IN, MAC_OLD, MAC_NEW and
// FINISH on one shared 40x24 multiplier. tready is high only between items,
// so no new sample pair is taken before the last one is through. A stalled
// master side holds the second upsample result back and leaves the first
// one waiting in the output register while filtering goes on.
module butterworth_resampler_2x (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] first_sample, [31:16] second_sample
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast
);
	import brs_pkg::*;

	cmd_t                      cmd;
	status_t                   status;
	logic signed [SAMPLE_W-1:0] sample;

	brs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	brs_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_sample (sample),
		.m_last   (m_tlast)
	);

	assign m_tdata = sample;

endmodule
